// ===== sv/csop_pkg.sv =====
`default_nettype none

package csop_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SWAIT,
    ST_RUN
  } state_e;

  // Input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_X    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALPHA_RE = 2'd0;
  localparam logic [1:0] CFG_ALPHA_IM = 2'd1;
  localparam logic [1:0] CFG_Y_LENGTH = 2'd2;

  localparam int unsigned ROW_W  = 10;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned DATA_W = 16;

  // Tag that travels alongside each operation in the multiply pipeline
  typedef struct packed {
    logic             valid;
    logic             scale;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  // Round a Q3.30 sum half up to Q1.15 and saturate to 16 bits
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [32:0] v);
    logic signed [33:0] biased;
    logic signed [18:0] shifted;
    logic signed [DATA_W-1:0] res;
    biased  = 34'(v) + 34'sd16384;
    shifted = biased[33:15];
    if (shifted > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (shifted < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = shifted[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/csop_ystore.sv =====
`default_nettype none

module csop_ystore
  import csop_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [2*DATA_W-1:0] wdata_i,
  input  wire logic                re_i,
  input  wire logic [AW-1:0]       raddr_i,
  output logic      [2*DATA_W-1:0] rdata_o
);

  logic [2*DATA_W-1:0] mem_q [DEPTH];
  logic [2*DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/csop_cmul.sv =====
`default_nettype none

module csop_cmul
  import csop_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire tag_t                     tag_i,
  input  wire logic signed [DATA_W-1:0] a_re_i,
  input  wire logic signed [DATA_W-1:0] a_im_i,
  input  wire logic signed [DATA_W-1:0] b_re_i,
  input  wire logic signed [DATA_W-1:0] b_im_i,
  output tag_t                          tag_o,
  output logic signed [DATA_W-1:0]      p_re_o,
  output logic signed [DATA_W-1:0]      p_im_o
);

  tag_t tag1_q, tag2_q, tag3_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic signed [32:0] s_re_q, s_im_q;
  logic signed [DATA_W-1:0] o_re_q, o_im_q;

  // Advance tags through the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // Stage 1: partial products; stage 2: sums; stage 3: round and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= a_re_i * b_re_i;
      p_ii_q <= a_im_i * b_im_i;
      p_ir_q <= a_im_i * b_re_i;
      p_ri_q <= a_re_i * b_im_i;
      s_re_q <= 33'(p_rr_q) - 33'(p_ii_q);
      s_im_q <= 33'(p_ir_q) + 33'(p_ri_q);
      o_re_q <= round_sat(s_re_q);
      o_im_q <= round_sat(s_im_q);
    end
  end

  assign tag_o  = tag3_q;
  assign p_re_o = o_re_q;
  assign p_im_o = o_im_q;

endmodule

`default_nettype wire

// ===== sv/complex_scaled_outer_product.sv =====
`default_nettype none
// An accepted x item is scaled by alpha, then multiplied by each y entry in turn.
// One result per cycle unless the output stalls; an x item holds the input until
// its n columns are issued (n = effective y length), set by one y store read port
// and one multiply pipeline. Loads write the y store. Reset is asynchronous, active
// low: alpha = 32767 + 0j, y_length = 1, pipeline emptied; y store not cleared.

module complex_scaled_outer_product
  import csop_pkg::*;
#(
  parameter int unsigned MAX_Y = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic [ROW_W-1:0]         index_i,
  input  wire logic signed [DATA_W-1:0] sample_re_i,
  input  wire logic signed [DATA_W-1:0] sample_im_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ROW_W-1:0]              row_o,
  output logic [COL_W-1:0]              col_o,
  output logic signed [DATA_W-1:0]      c_re_o,
  output logic signed [DATA_W-1:0]      c_im_o,
  output logic                          last_o
);

  localparam int unsigned AW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] alpha_re_q, alpha_im_q;
  logic [6:0]               y_length_q;
  logic signed [DATA_W-1:0] x_re_q, x_im_q;
  logic signed [DATA_W-1:0] sx_re_q, sx_im_q;
  logic [ROW_W-1:0]         row_q;
  logic [6:0]               n_q, n_eff;
  logic [COL_W-1:0]         col_q, col_d;
  tag_t                     tag_m_q, tag_m_d, cm_tag_in, cm_tag_out;

  logic                     en;
  logic                     in_acc, x_acc, load_we;
  logic                     issue, scale_issue, scale_done, col_last;
  logic [2*DATA_W-1:0]      y_rdata;
  logic signed [DATA_W-1:0] op_a_re, op_a_im, op_b_re, op_b_im;
  logic signed [DATA_W-1:0] p_re, p_im;

  // Pipeline stalls only while a result beat waits on the output
  assign en = !(cm_tag_out.valid && !cm_tag_out.scale && !out_ready_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign x_acc       = in_acc && (kind_i == KIND_X);
  assign load_we     = in_acc && (kind_i == KIND_LOAD) && (index_i < ROW_W'(MAX_Y));
  assign n_eff       = (y_length_q > 7'(MAX_Y)) ? 7'(MAX_Y) : y_length_q;
  assign col_last    = (7'(col_q) + 7'd1 == n_q);
  assign scale_done  = cm_tag_out.valid && cm_tag_out.scale;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_re_q <= 16'sh7fff;
      alpha_im_q <= '0;
      y_length_q <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ALPHA_RE: alpha_re_q <= cfg_data_i;
        CFG_ALPHA_IM: alpha_im_q <= cfg_data_i;
        CFG_Y_LENGTH: y_length_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and issue strobes
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    issue       = 1'b0;
    scale_issue = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (x_acc) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (en && !tag_m_q.valid) begin
          scale_issue = 1'b1;
          state_d     = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        if (scale_done) begin
          state_d = (n_q == 7'd0) ? ST_IDLE : ST_RUN;
          col_d   = '0;
        end
      end
      ST_RUN: begin
        if (en) begin
          issue = 1'b1;
          if (col_last) begin
            state_d = ST_IDLE;
            col_d   = '0;
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  // Hold the x item and its row length
  always_ff @(posedge clk_i) begin
    if (x_acc) begin
      x_re_q <= sample_re_i;
      x_im_q <= sample_im_i;
      row_q  <= index_i;
      n_q    <= n_eff;
    end
  end

  // Keep alpha*x once it leaves the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_re_q <= '0;
      sx_im_q <= '0;
    end else if (scale_done) begin
      sx_re_q <= p_re;
      sx_im_q <= p_im;
    end
  end

  csop_ystore #(
    .DEPTH (MAX_Y),
    .AW    (AW)
  ) u_ystore (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (index_i[AW-1:0]),
    .wdata_i ({sample_re_i, sample_im_i}),
    .re_i    (issue),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (y_rdata)
  );

  // Tag for the store read stage
  always_comb begin
    tag_m_d       = '0;
    tag_m_d.valid = issue;
    tag_m_d.row   = row_q;
    tag_m_d.col   = col_q;
    tag_m_d.last  = col_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_m_q <= '0;
    end else if (en) begin
      tag_m_q <= tag_m_d;
    end
  end

  // Select multiplier operands: alpha*x, or alpha*x times y entry
  always_comb begin
    if (scale_issue) begin
      cm_tag_in       = '0;
      cm_tag_in.valid = 1'b1;
      cm_tag_in.scale = 1'b1;
      op_a_re         = x_re_q;
      op_a_im         = x_im_q;
      op_b_re         = alpha_re_q;
      op_b_im         = alpha_im_q;
    end else begin
      cm_tag_in       = tag_m_q;
      op_a_re         = sx_re_q;
      op_a_im         = sx_im_q;
      op_b_re         = y_rdata[2*DATA_W-1:DATA_W];
      op_b_im         = y_rdata[DATA_W-1:0];
    end
  end

  csop_cmul u_cmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (cm_tag_in),
    .a_re_i (op_a_re),
    .a_im_i (op_a_im),
    .b_re_i (op_b_re),
    .b_im_i (op_b_im),
    .tag_o  (cm_tag_out),
    .p_re_o (p_re),
    .p_im_o (p_im)
  );

  // Result beat comes straight from the multiplier output register
  assign out_valid_o = cm_tag_out.valid && !cm_tag_out.scale;
  assign row_o       = cm_tag_out.row;
  assign col_o       = cm_tag_out.col;
  assign last_o      = cm_tag_out.last;
  assign c_re_o      = p_re;
  assign c_im_o      = p_im;

`ifndef SYNTH
  a_run_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((7'(col_q) < n_q) && (n_q != 7'd0)))
    else $error("column counter beyond row length");

  a_scale_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_issue |-> !tag_m_q.valid)
    else $error("scale op collides with store read data");

  a_scale_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (state_q == ST_SWAIT))
    else $error("scale op returned outside its wait state");

  a_idle_after_last_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && col_last) |=> (state_q == ST_IDLE))
    else $error("sequencer left running after last column");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_complex_scaled_outer_product.sv =====
`timescale 1ns / 100ps

module tb_complex_scaled_outer_product;
  import csop_pkg::*;

  localparam int Y_DEPTH       = 64;
  // pipeline depth plus the input hold of an x item with no columns
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 1500000;
  // index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic                     last;
  } product_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i;
  logic [DATA_W-1:0]        cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     kind_i;
  logic [ROW_W-1:0]         index_i;
  logic signed [DATA_W-1:0] sample_re_i;
  logic signed [DATA_W-1:0] sample_im_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [ROW_W-1:0]         row_o;
  logic [COL_W-1:0]         col_o;
  logic signed [DATA_W-1:0] c_re_o;
  logic signed [DATA_W-1:0] c_im_o;
  logic                     last_o;

  // predicted block state
  logic signed [DATA_W-1:0] alpha_re;
  logic signed [DATA_W-1:0] alpha_im;
  logic [6:0]               y_len;
  logic signed [DATA_W-1:0] y_re_mem [Y_DEPTH];
  logic signed [DATA_W-1:0] y_im_mem [Y_DEPTH];
  logic signed [DATA_W-1:0] scaled_re;
  logic signed [DATA_W-1:0] scaled_im;
  // entries written so far; no x item may read past them
  logic                     y_loaded [Y_DEPTH];
  product_t                 expected_products [$];

  int sender_max_gap     = 12;
  int receiver_max_stall = 12;
  int hold_off_cycles    = 0;
  int error_count        = 0;
  int cycle_count        = 0;
  int items_sent         = 0;
  int products_seen      = 0;
  int cfg_writes         = 0;

  complex_scaled_outer_product u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_o       (row_o),
    .col_o       (col_o),
    .c_re_o      (c_re_o),
    .c_im_o      (c_im_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Round a Q3.30 sum half up to Q1.15, then clamp to 16 bits
  function automatic logic signed [DATA_W-1:0] q15_round_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[DATA_W-1:0];
  endfunction

  task automatic cmul_q15(input logic signed [DATA_W-1:0] ar, ai, br, bi,
                          output logic signed [DATA_W-1:0] pr, pi);
    longint re_acc;
    longint im_acc;
    re_acc = longint'(ar) * longint'(br) - longint'(ai) * longint'(bi);
    im_acc = longint'(ai) * longint'(br) + longint'(ar) * longint'(bi);
    pr = q15_round_sat(re_acc);
    pi = q15_round_sat(im_acc);
  endtask

  function automatic int columns_per_row();
    return (y_len > Y_DEPTH) ? Y_DEPTH : int'(y_len);
  endfunction

  // Update the store on a load, or queue one product per column on an x item
  task automatic predict_products(input logic kind, input logic [ROW_W-1:0] idx,
                                  input logic signed [DATA_W-1:0] s_re, s_im);
    product_t p;
    int       n;
    if (kind == KIND_LOAD) begin
      if (idx < Y_DEPTH) begin
        y_re_mem[idx] = s_re;
        y_im_mem[idx] = s_im;
        y_loaded[idx] = 1'b1;
      end
    end else begin
      cmul_q15(s_re, s_im, alpha_re, alpha_im, scaled_re, scaled_im);
      n = columns_per_row();
      for (int j = 0; j < n; j++) begin
        p.row  = idx;
        p.col  = COL_W'(j);
        cmul_q15(scaled_re, scaled_im, y_re_mem[j], y_im_mem[j], p.c_re, p.c_im);
        p.last = (j == n - 1);
        expected_products.push_back(p);
      end
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = DATA_W'($urandom_range(0, 32)) - 16'sd16;
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // Offer one input beat after a random gap; entered and left at a falling edge
  task automatic send_item(input logic kind, input logic [ROW_W-1:0] idx,
                           input logic signed [DATA_W-1:0] s_re, s_im);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    kind_i      = kind;
    index_i     = idx;
    sample_re_i = s_re;
    sample_im_i = s_im;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_products(kind, idx, s_re, s_im);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_x(input logic [ROW_W-1:0] idx);
    send_item(KIND_X, idx, rand_sample(), rand_sample());
  endtask

  // Load every y entry the current length reads that was never written
  task automatic fill_missing_y();
    int n;
    n = columns_per_row();
    for (int j = 0; j < n; j++) begin
      if (!y_loaded[j]) send_item(KIND_LOAD, ROW_W'(j), rand_sample(), rand_sample());
    end
  endtask

  // Drop valid, wait for every queued product, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ALPHA_RE: alpha_re = data;
      CFG_ALPHA_IM: alpha_im = data;
      CFG_Y_LENGTH: y_len = data[6:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reset values of alpha and length; half-up rounding on both signs
  task automatic test_reset_values();
    send_item(KIND_LOAD, 10'd0, 16'sd16384, -16'sd16384);
    send_item(KIND_X, 10'd0, 16'sd1, 16'sd0);
    send_item(KIND_X, 10'd1023, 16'sh7fff, 16'sh8000);
  endtask

  // Full-scale samples and alpha, saturation of the scaled x and the product
  task automatic test_extremes();
    wait_idle();
    write_register(CFG_Y_LENGTH, 16'd4);
    write_register(CFG_ALPHA_RE, 16'h8000);
    write_register(CFG_ALPHA_IM, 16'h0000);
    send_item(KIND_LOAD, 10'd0, 16'sh7fff, 16'sh7fff);
    send_item(KIND_LOAD, 10'd1, 16'sh8000, 16'sh8000);
    send_item(KIND_LOAD, 10'd2, 16'sh8000, 16'sh7fff);
    send_item(KIND_LOAD, 10'd3, 16'sd0, -16'sd1);
    send_item(KIND_X, 10'd0, 16'sh8000, 16'sd0);
    send_item(KIND_X, 10'd1023, 16'sh7fff, 16'sh8000);
    send_item(KIND_X, 10'd512, 16'sd0, 16'sd0);
    wait_idle();
    write_register(CFG_ALPHA_RE, 16'h7fff);
    write_register(CFG_ALPHA_IM, 16'h8000);
    send_item(KIND_X, 10'd341, 16'sh8000, 16'sh8000);
    send_item(KIND_X, 10'd682, 16'sd1, -16'sd1);
  endtask

  // Loads past the store must not alias onto written entries
  task automatic test_ignored_loads();
    send_item(KIND_LOAD, 10'd64, 16'sd1234, -16'sd1234);
    send_item(KIND_LOAD, 10'd1023, 16'sh8000, 16'sh7fff);
    send_item(KIND_X, 10'd7, 16'sh4000, 16'shc000);
  endtask

  // Zero length: x items emit nothing; spare register index is a no-op
  task automatic test_zero_length();
    wait_idle();
    write_register(CFG_SPARE, 16'hffff);
    write_register(CFG_Y_LENGTH, 16'd0);
    send_item(KIND_X, 10'd100, 16'sh7fff, 16'sh7fff);
    send_item(KIND_X, 10'd101, 16'sh8000, 16'sd5);
  endtask

  // Hold the output off long enough to back up the input, then drain fully
  task automatic test_backpressure();
    wait_idle();
    write_register(CFG_Y_LENGTH, 16'd8);
    fill_missing_y();
    sender_max_gap  = 0;
    hold_off_cycles = 300;
    for (int k = 0; k < 12; k++) send_x(ROW_W'($urandom));
    wait_idle();
    sender_max_gap = 12;
  endtask

  // Phases of mostly load-then-x traffic under changing alpha and length
  task automatic test_random_phases();
    int         pick;
    int         useful;
    int         n;
    logic [6:0] len;
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_register(CFG_ALPHA_RE, 16'h8000);
          write_register(CFG_ALPHA_IM, 16'h8000);
        end
        1: begin
          write_register(CFG_ALPHA_RE, 16'h7fff);
          write_register(CFG_ALPHA_IM, 16'h7fff);
        end
        default: begin
          write_register(CFG_ALPHA_RE, rand_sample());
          write_register(CFG_ALPHA_IM, rand_sample());
        end
      endcase
      case (phase)
        0: len = 7'd1;
        1: len = 7'd8;
        2: len = 7'd3;
        3: len = 7'd16;
        4: len = 7'd2;
        default: len = 7'($urandom_range(1, 12));
      endcase
      // upper data bits are outside the length field
      write_register(CFG_Y_LENGTH, {9'($urandom), len});
      sender_max_gap     = (phase == 2 || phase == 4) ? 0 : 12;
      receiver_max_stall = (phase == 3 || phase == 4) ? 0 : 12;
      n = columns_per_row();
      useful = 0;
      while (useful < 30) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_item(KIND_LOAD, ROW_W'($urandom_range(Y_DEPTH, 1023)),
                    rand_sample(), rand_sample());
        end else if (pick <= 3) begin
          send_item(KIND_LOAD, ROW_W'($urandom_range(0, n - 1)), rand_sample(), rand_sample());
          useful++;
        end else if (pick == 4) begin
          send_item(KIND_LOAD, ROW_W'($urandom_range(0, Y_DEPTH - 1)),
                    rand_sample(), rand_sample());
          useful++;
        end else begin
          fill_missing_y();
          send_x(ROW_W'($urandom));
          useful++;
        end
      end
    end
    sender_max_gap     = 12;
    receiver_max_stall = 12;
  endtask

  // Lengths at and above the store depth all give full 64-column rows
  task automatic test_length_limits();
    logic [6:0] lengths [3];
    lengths = '{7'd127, 7'd65, 7'd64};
    for (int k = 0; k < 3; k++) begin
      wait_idle();
      write_register(CFG_ALPHA_RE, rand_sample());
      write_register(CFG_ALPHA_IM, rand_sample());
      write_register(CFG_Y_LENGTH, {9'd0, lengths[k]});
      fill_missing_y();
      send_x(ROW_W'($urandom));
      send_x(ROW_W'($urandom));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ALPHA_RE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_LOAD;
    index_i     = '0;
    sample_re_i = '0;
    sample_im_i = '0;
    alpha_re    = 16'sh7fff;
    alpha_im    = 16'sd0;
    y_len       = 7'd1;
    scaled_re   = '0;
    scaled_im   = '0;
    for (int j = 0; j < Y_DEPTH; j++) begin
      y_re_mem[j] = '0;
      y_im_mem[j] = '0;
      y_loaded[j] = 1'b0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_extremes();
    test_ignored_loads();
    test_zero_length();
    test_backpressure();
    test_random_phases();
    test_length_limits();
    wait_idle();

    $display("Sent %0d input beats and %0d register writes; checked %0d product beats.",
             items_sent, cfg_writes, products_seen);
    $display("Lengths 0 to 127, full-scale alpha and samples, long output stall covered.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Accept product beats after a random stall, or a requested long hold-off
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = $urandom_range(0, receiver_max_stall);
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Compare each product beat with the oldest prediction
  always @(posedge clk_i) begin : product_check
    product_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      products_seen++;
      if (expected_products.size() == 0) begin
        error_count++;
        $error("unexpected product beat: row %0d col %0d", row_o, col_o);
      end else begin
        want = expected_products.pop_front();
        if (row_o !== want.row) begin
          error_count++;
          $error("row: expected %0d, actual %0d", want.row, row_o);
        end
        if (col_o !== want.col) begin
          error_count++;
          $error("col: expected %0d, actual %0d", want.col, col_o);
        end
        if (c_re_o !== want.c_re) begin
          error_count++;
          $error("c_re: expected %0d, actual %0d", want.c_re, c_re_o);
        end
        if (c_im_o !== want.c_im) begin
          error_count++;
          $error("c_im: expected %0d, actual %0d", want.c_im, c_im_o);
        end
        if (last_o !== want.last) begin
          error_count++;
          $error("last: expected %0d, actual %0d", want.last, last_o);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d products outstanding",
             cycle_count, expected_products.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
